// ===== rtl/cri_pkg.sv =====
// Shared types and constants for the color ramp interpolator.
// No dependencies.
package cri_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int KEY_W       = 32;
	localparam int COMP_W      = 16;
	localparam int FRAC_W      = 17;
	localparam int DIV_STEPS   = 17;
	localparam int MUL_STEPS   = 3;
	localparam int STEP_W      = 5;
	localparam int PROD_W      = FRAC_W + 1 + COMP_W + 1;

	typedef enum logic [1:0] {
		FUNC_CLEAR  = 2'd0,
		FUNC_APPEND = 2'd1,
		FUNC_LOOKUP = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef logic [2:0][COMP_W-1:0] color_t;

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_SCAN    = 7'b0000010,
		ST_PICK_RD = 7'b0000100,
		ST_PICK    = 7'b0001000,
		ST_DIV     = 7'b0010000,
		ST_MUL     = 7'b0100000,
		ST_FIN     = 7'b1000000
	} state_t;

endpackage

// ===== rtl/color_ramp_interpolator_unit.sv =====
// Color ramp lookup: key/color store, serial key scan, serial fraction divider
// and one shared multiplier for the three components. Uses cri_pkg.
// Clear and append finish in ST_FIN; a lookup scans the N stored keys, one per
// cycle from the key memory port, then either picks an end color or runs the
// 17-step divider and the multiplier. One word in flight at a time.
// Reset clears the entry count and control state; store contents stay as is.
module color_ramp_interpolator_unit
	import cri_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               func,
	input  logic signed [KEY_W-1:0]  key_value,
	input  logic signed [COMP_W-1:0] red_in,
	input  logic signed [COMP_W-1:0] green_in,
	input  logic signed [COMP_W-1:0] blue_in,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [COMP_W-1:0] red_out,
	output logic signed [COMP_W-1:0] green_out,
	output logic signed [COMP_W-1:0] blue_out,
	output logic [1:0]               status
);

	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	state_t                  state_q;
	logic [CNT_W-1:0]        count_q;
	logic [IDX_W-1:0]        idx_q;
	logic signed [KEY_W-1:0] val_q;
	logic signed [KEY_W-1:0] key_rd_q;
	logic signed [KEY_W-1:0] key_prev_q;
	logic [KEY_W:0]          rem_q;
	logic [KEY_W:0]          den_q;
	logic [FRAC_W-1:0]       quo_q;
	logic [STEP_W-1:0]       step_q;
	color_t                  col_rd_q;
	color_t                  c_lo_q;
	color_t                  res_q;
	status_t                 res_stat_q;
	logic signed [PROD_W-1:0] prod_q;

	logic signed [KEY_W-1:0] key_mem [ENTRIES];
	color_t                  color_mem [ENTRIES];

	logic                    accept;
	logic                    fin_load;
	logic                    full;
	logic [CNT_W-1:0]        last_idx;
	logic                    at_last;
	logic                    hit;
	logic [IDX_W-1:0]        key_raddr;
	logic [IDX_W-1:0]        col_raddr;
	logic                    col_ren;
	logic [KEY_W:0]          num_w;
	logic [KEY_W:0]          gap_w;
	logic                    ge;
	logic [KEY_W:0]          rem_sub;
	logic [1:0]              mi;
	logic [1:0]              ri;
	logic signed [COMP_W:0]  diff;
	logic signed [PROD_W-1:0] prod;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign fin_load = (state_q == ST_FIN) && (!out_valid || !out_stall);
	assign full     = (count_q >= CNT_W'(ENTRIES));
	assign last_idx = count_q - CNT_W'(1);
	assign at_last  = (CNT_W'(idx_q) == last_idx);
	assign hit      = (val_q <= key_rd_q);

	assign num_w = {val_q[KEY_W-1], val_q} - {key_prev_q[KEY_W-1], key_prev_q};
	assign gap_w = {key_rd_q[KEY_W-1], key_rd_q} - {key_prev_q[KEY_W-1], key_prev_q};

	assign ge      = (rem_q >= den_q);
	assign rem_sub = ge ? (rem_q - den_q) : rem_q;

	assign mi   = step_q[1:0];
	assign ri   = step_q[1:0] - 2'd1;
	assign diff = {col_rd_q[mi][COMP_W-1], col_rd_q[mi]} - {c_lo_q[mi][COMP_W-1], c_lo_q[mi]};
	assign prod = $signed({1'b0, quo_q}) * diff;

	always_comb begin
		key_raddr = (state_q == ST_IDLE) ? '0 : IDX_W'(idx_q + IDX_W'(1));
		col_raddr = idx_q;
		col_ren   = 1'b0;
		case (state_q)
			ST_PICK_RD: begin
				col_ren = 1'b1;
			end
			ST_DIV: begin
				col_ren = (step_q < STEP_W'(2));
				if (step_q == '0) begin
					col_raddr = idx_q - IDX_W'(1);
				end
			end
			default: begin
				col_ren = 1'b0;
			end
		endcase
	end

	// store
	always_ff @(posedge clk) begin
		if (accept && (func == FUNC_APPEND) && !full) begin
			key_mem[count_q[IDX_W-1:0]]   <= key_value;
			color_mem[count_q[IDX_W-1:0]] <= {blue_in, green_in, red_in};
		end
		key_rd_q <= key_mem[key_raddr];
		if (col_ren) begin
			col_rd_q <= color_mem[col_raddr];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (fin_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (func)
							FUNC_CLEAR: begin
								count_q <= '0;
								state_q <= ST_FIN;
							end
							FUNC_APPEND: begin
								if (!full) begin
									count_q <= count_q + CNT_W'(1);
								end
								state_q <= ST_FIN;
							end
							FUNC_LOOKUP: begin
								state_q <= (count_q != '0) ? ST_SCAN : ST_FIN;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (hit) begin
						state_q <= (idx_q == '0) ? ST_PICK_RD : ST_DIV;
					end else if (at_last) begin
						state_q <= ST_PICK_RD;
					end
				end
				ST_PICK_RD: begin
					state_q <= ST_PICK;
				end
				ST_PICK: begin
					state_q <= ST_FIN;
				end
				ST_DIV: begin
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (step_q == STEP_W'(MUL_STEPS)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					val_q      <= key_value;
					idx_q      <= '0;
					res_q      <= '0;
					res_stat_q <= ((func == FUNC_APPEND) && full) ? STAT_FULL :
						((func == FUNC_LOOKUP) && (count_q == '0)) ? STAT_EMPTY : STAT_OK;
				end
			end
			ST_SCAN: begin
				step_q <= '0;
				quo_q  <= '0;
				rem_q  <= num_w;
				den_q  <= gap_w;
				if (!hit && !at_last) begin
					key_prev_q <= key_rd_q;
					idx_q      <= idx_q + IDX_W'(1);
				end
			end
			ST_PICK: begin
				res_q <= col_rd_q;
			end
			ST_DIV: begin
				// restoring divide, one quotient bit per cycle
				quo_q <= {quo_q[FRAC_W-2:0], ge};
				rem_q <= {rem_sub[KEY_W-1:0], 1'b0};
				if (step_q == STEP_W'(1)) begin
					c_lo_q <= col_rd_q;
				end
				step_q <= (step_q == STEP_W'(DIV_STEPS - 1)) ? '0 : step_q + STEP_W'(1);
			end
			ST_MUL: begin
				if (step_q < STEP_W'(MUL_STEPS)) begin
					prod_q <= prod;
				end
				if (step_q != '0) begin
					res_q[ri] <= c_lo_q[ri] + prod_q[COMP_W+15:16];
				end
				step_q <= step_q + STEP_W'(1);
			end
			default: begin
				step_q <= step_q;
			end
		endcase
	end

	// output word
	always_ff @(posedge clk) begin
		if (fin_load) begin
			red_out   <= res_q[0];
			green_out <= res_q[1];
			blue_out  <= res_q[2];
			status    <= res_stat_q;
		end
	end

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for color_ramp_interpolator_unit: directed and random ramp words
// through the valid/stall channels, checked against a built-in ramp predictor.
// Depends on rtl/cri_pkg.sv and rtl/color_ramp_interpolator_unit.sv.
`timescale 1ns / 1ps

module testbench
	import cri_pkg::*;
();

	localparam int RAMP_DEPTH  = ENTRIES_DEF;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic signed [COMP_W-1:0] red;
		logic signed [COMP_W-1:0] green;
		logic signed [COMP_W-1:0] blue;
		status_t                  status;
	} answer_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [1:0]               func = FUNC_NONE;
	logic signed [KEY_W-1:0]  key_value = '0;
	logic signed [COMP_W-1:0] red_in = '0;
	logic signed [COMP_W-1:0] green_in = '0;
	logic signed [COMP_W-1:0] blue_in = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic signed [COMP_W-1:0] red_out;
	logic signed [COMP_W-1:0] green_out;
	logic signed [COMP_W-1:0] blue_out;
	logic [1:0]               status;

	// shadow ramp
	longint                   ramp_key [RAMP_DEPTH];
	logic signed [COMP_W-1:0] ramp_color [RAMP_DEPTH][3];
	int                       ramp_len = 0;

	answer_t pending_answers[$];
	int      mismatch_count = 0;
	int      words_sent = 0;
	int      cycle_count = 0;
	bit      tx_idle = 1'b1;
	bit      rx_idle = 1'b1;
	bit      valid_drive = 1'b0;
	int      hold_req = 0;
	int      hold_left = 0;
	int      rx_wait = 0;

	color_ramp_interpolator_unit #(
		.ENTRIES(RAMP_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.key_value(key_value),
		.red_in(red_in),
		.green_in(green_in),
		.blue_in(blue_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.red_out(red_out),
		.green_out(green_out),
		.blue_out(blue_out),
		.status(status)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic answer_t apply_ramp_word(func_t f, logic signed [KEY_W-1:0] kv,
			logic signed [COMP_W-1:0] r, logic signed [COMP_W-1:0] g,
			logic signed [COMP_W-1:0] b);
		answer_t                  a;
		logic signed [COMP_W-1:0] comp [3];
		int                       i, lo, hi;
		longint                   den, frac, c0, c1, mix;
		comp = '{default: '0};
		a.status = STAT_OK;
		case (f)
			FUNC_CLEAR: ramp_len = 0;
			FUNC_APPEND: begin
				if (ramp_len >= RAMP_DEPTH) begin
					a.status = STAT_FULL;
				end else begin
					ramp_key[ramp_len] = kv;
					ramp_color[ramp_len] = '{r, g, b};
					ramp_len++;
				end
			end
			FUNC_LOOKUP: begin
				if (ramp_len == 0) begin
					a.status = STAT_EMPTY;
				end else begin
					lo = 0;
					hi = 0;
					i = 0;
					while (i < ramp_len && longint'(kv) > ramp_key[i]) begin
						lo = i;
						hi = i + 1;
						i++;
					end
					if (i == ramp_len)
						hi = lo;
					frac = 0;
					if (lo != hi) begin
						den = ramp_key[hi] - ramp_key[lo];
						if (den > 0)
							frac = ((longint'(kv) - ramp_key[lo]) <<< 16) / den;
					end
					// floor of the Q1.16 blend; frac is 0 at end colors
					for (int k = 0; k < 3; k++) begin
						c0 = ramp_color[lo][k];
						c1 = ramp_color[hi][k];
						mix = c0 + ((frac * (c1 - c0)) >>> 16);
						comp[k] = mix[COMP_W-1:0];
					end
				end
			end
			default: ;
		endcase
		a.red = comp[0];
		a.green = comp[1];
		a.blue = comp[2];
		return a;
	endfunction

	function automatic logic signed [KEY_W-1:0] clamp_key(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[KEY_W-1:0];
	endfunction

	function automatic logic signed [COMP_W-1:0] rand_comp();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '0;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_word(func_t f, logic signed [KEY_W-1:0] kv,
			logic signed [COMP_W-1:0] r, logic signed [COMP_W-1:0] g,
			logic signed [COMP_W-1:0] b);
		int gap;
		gap = tx_idle ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			if (valid_drive)
				in_valid <= 1'b0;
			valid_drive = 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		valid_drive = 1'b1;
		func <= f;
		key_value <= kv;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_answers.push_back(apply_ramp_word(f, kv, r, g, b));
		if (f != FUNC_NONE)
			words_sent++;
	endtask

	task automatic wait_drain();
		if (valid_drive)
			in_valid <= 1'b0;
		valid_drive = 1'b0;
		@(posedge clk);
		while (pending_answers.size() > 0)
			@(posedge clk);
	endtask

	// receiver: random stall per word, plus long holds on request
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (out_valid && !out_stall)
				rx_wait = rx_idle ? $urandom_range(0, 4) : 0;
			else if (rx_wait > 0)
				rx_wait--;
			out_stall <= (rx_wait > 0);
		end
	end

	always @(posedge clk) begin : check_answers
		answer_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_answers.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result word: r=%0d g=%0d b=%0d st=%0d",
						red_out, green_out, blue_out, status);
			end else begin
				want = pending_answers.pop_front();
				if (red_out !== want.red || green_out !== want.green ||
						blue_out !== want.blue || status !== want.status) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: want r=%0d g=%0d b=%0d st=%0d, got r=%0d g=%0d b=%0d st=%0d",
							want.red, want.green, want.blue, want.status,
							red_out, green_out, blue_out, status);
				end
			end
		end
	end

	task automatic test_empty_and_unused();
		send_word(FUNC_LOOKUP, 32'sh0, 16'sh0, 16'sh0, 16'sh0);
		send_word(FUNC_NONE, 32'shffffffff, 16'shffff, 16'shffff, 16'shffff);
		send_word(FUNC_CLEAR, 32'sh7fffffff, 16'sh7fff, 16'sh8000, 16'sh1234);
		send_word(FUNC_LOOKUP, 32'sh80000000, 16'shffff, 16'shffff, 16'shffff);
		send_word(FUNC_NONE, 32'sh0, 16'sh0, 16'sh0, 16'sh0);
		wait_drain();
	endtask

	task automatic test_extremes();
		send_word(FUNC_CLEAR, '0, '0, '0, '0);
		send_word(FUNC_APPEND, 32'sh80000000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_word(FUNC_APPEND, 32'sh0, 16'sh7fff, 16'sh0, 16'shffff);
		send_word(FUNC_APPEND, 32'sh7fffffff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_word(FUNC_LOOKUP, 32'sh80000000, '0, '0, '0);
		send_word(FUNC_LOOKUP, 32'sh7fffffff, '0, '0, '0);
		send_word(FUNC_LOOKUP, 32'shffffffff, '0, '0, '0);
		send_word(FUNC_LOOKUP, 32'sh80000001, '0, '0, '0);
		send_word(FUNC_LOOKUP, 32'sh1, '0, '0, '0);
		send_word(FUNC_LOOKUP, 32'sh40000000, '0, '0, '0);
		// single entry: end color on both sides
		send_word(FUNC_CLEAR, '0, '0, '0, '0);
		send_word(FUNC_APPEND, 32'sh00010000, 16'sh1000, 16'shf000, 16'sh0800);
		send_word(FUNC_LOOKUP, 32'sh0000ffff, '0, '0, '0);
		send_word(FUNC_LOOKUP, 32'sh00010001, '0, '0, '0);
		wait_drain();
	endtask

	task automatic test_full_ramp();
		send_word(FUNC_CLEAR, '0, '0, '0, '0);
		for (int j = 0; j < RAMP_DEPTH; j++)
			send_word(FUNC_APPEND, 32'(j / 2 * 32'h00030000 + j % 2 * 32'h00008000),
				rand_comp(), rand_comp(), rand_comp());
		send_word(FUNC_APPEND, 32'sh7fffffff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_word(FUNC_APPEND, 32'sh0, '0, '0, '0);
		send_word(FUNC_LOOKUP, 32'sh00050000, '0, '0, '0);
		send_word(FUNC_LOOKUP, 32'sh7fffffff, '0, '0, '0);
		wait_drain();
	endtask

	task automatic test_long_hold();
		tx_idle = 1'b0;
		hold_req = 300;
		send_word(FUNC_CLEAR, '0, '0, '0, '0);
		for (int j = 0; j < 6; j++)
			send_word(FUNC_APPEND, 32'(j * 32'h00100000 - 32'h00200000),
				rand_comp(), rand_comp(), rand_comp());
		for (int j = 0; j < 6; j++)
			send_word(FUNC_LOOKUP, 32'($urandom_range(0, 32'h00700000)) - 32'sh00280000,
				'0, '0, '0);
		wait_drain();
		tx_idle = 1'b1;
	endtask

	task automatic test_random_ramps(int target);
		int     stop_at, n, m, style, idx;
		longint keys[$];
		longint base, span, probe;
		stop_at = words_sent + target;
		while (words_sent < stop_at) begin
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			style = $urandom_range(0, 9);
			// style 9 keeps the old ramp, so appends may run into a full ramp
			if (style != 9)
				send_word(FUNC_CLEAR, 32'($urandom), rand_comp(), rand_comp(), rand_comp());
			if (style == 7)
				send_word(FUNC_LOOKUP, 32'($urandom), rand_comp(), rand_comp(), rand_comp());
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(RAMP_DEPTH - 2, RAMP_DEPTH + 2)
				: $urandom_range(1, 6);
			base = ($urandom_range(0, 4) == 0) ? longint'(int'($urandom))
				: longint'($urandom_range(0, 1 << 25)) - (1 << 24);
			span = longint'(1) <<< $urandom_range(0, 32);
			keys.delete();
			for (int j = 0; j < n; j++)
				keys.push_back(base + longint'($urandom) % (span + 1));
			// style 8: keys out of order
			if (style != 8)
				keys.sort();
			foreach (keys[j])
				send_word(FUNC_APPEND, clamp_key(keys[j]), rand_comp(), rand_comp(),
					rand_comp());
			m = $urandom_range(1, 8);
			for (int j = 0; j < m; j++) begin
				if ($urandom_range(0, 7) == 0)
					send_word(FUNC_NONE, 32'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom));
				idx = $urandom_range(0, keys.size() - 1);
				case ($urandom_range(0, 5))
					0: probe = keys[idx];
					1, 2: probe = keys[idx] + longint'($urandom) % (span + 1) - span / 2;
					3: probe = keys[idx] - $urandom_range(0, 3);
					4: probe = $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
					default: probe = longint'(int'($urandom));
				endcase
				send_word(FUNC_LOOKUP, clamp_key(probe), rand_comp(), rand_comp(),
					rand_comp());
			end
			if ($urandom_range(0, 15) == 0)
				wait_drain();
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_unused();
		test_extremes();
		test_full_ramp();
		test_long_hold();
		test_random_ramps(1400);
		wait_drain();
		repeat (64) @(posedge clk);
		if (mismatch_count == 0 && pending_answers.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/cri_pkg.sv
rtl/color_ramp_interpolator_unit.sv
dv/testbench.sv
